>>> sv/u8_audio_upsample_lowpass_unit_macros.svh
// Assertion macros for the upsampler RTL.
`ifndef U8_AUDIO_UPSAMPLE_LOWPASS_UNIT_MACROS_SVH
`define U8_AUDIO_UPSAMPLE_LOWPASS_UNIT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define U8UP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define U8UP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> sv/u8up_pkg.sv
// Shared types and constants for the upsampler with one-pole low-pass.
`default_nettype none

package u8up_pkg;

  // Q1.15 unity coefficient.
  localparam logic [15:0] ALPHA_ONE = 16'h8000;

  // Default upper bound on outputs per input byte.
  localparam int unsigned MAX_RATIO_DEF = 8;

  // Field widths.
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned RATIO_W    = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned T1_W       = 17;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_RATIO = 1'b0,
    CFG_ALPHA = 1'b1
  } cfg_idx_e;

  // Control that selects how the filter datapath forms one output.
  typedef struct packed {
    logic bypass;      // pass the widened sample through unfiltered
    logic clear_hist;  // treat the previous output as zero
  } lpf_ctrl_t;

endpackage

`default_nettype wire

>>> sv/u8up_lpf.sv
// One-pole low-pass datapath: one filtered output from the scaled input and history.
`default_nettype none

module u8up_lpf
  import u8up_pkg::*;
(
  input  wire logic signed [T1_W-1:0]     t1_i,    // trunc0(x*a/32768)
  input  wire logic signed [SAMPLE_W-1:0] x_i,     // widened sample for bypass
  input  wire logic [15:0]                beta_i,  // 32768 - a
  input  wire logic signed [SAMPLE_W-1:0] prev_i,  // previous output
  input  wire lpf_ctrl_t                  ctrl_i,
  output logic signed [SAMPLE_W-1:0]      y_o
);

  logic signed [SAMPLE_W-1:0] hist;
  logic signed [32:0]         prod;
  logic signed [34:0]         num;
  logic signed [34:0]         num_adj;
  logic signed [19:0]         ysh;
  logic signed [SAMPLE_W-1:0] ysat;

  // History term, cleared at the start of a new sound.
  assign hist = ctrl_i.clear_hist ? '0 : prev_i;
  assign prod = $signed({1'b0, beta_i}) * hist;

  // Sum in units of 1/32768, then divide with truncation toward zero.
  assign num     = {{3{t1_i[T1_W-1]}}, t1_i, 15'd0} + {{2{prod[32]}}, prod};
  assign num_adj = num + (num[34] ? 35'sd32767 : 35'sd0);
  assign ysh     = num_adj[34:15];

  // Saturate to the signed 16-bit range.
  always_comb begin
    if (ysh > 20'sd32767) begin
      ysat = 16'sh7fff;
    end else if (ysh < -20'sd32768) begin
      ysat = 16'sh8000;
    end else begin
      ysat = ysh[SAMPLE_W-1:0];
    end
  end

  assign y_o = ctrl_i.bypass ? x_i : ysat;

endmodule

`default_nettype wire

>>> sv/u8_audio_upsample_lowpass_unit.sv
// Top level: 8-bit mono to 16-bit stereo upsampler with one-pole low-pass.
//
//  Channel   Direction  Handshake                     Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata[7:0] sample_byte, tuser new_sound
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata left/right, tlast last_of_run
//  cfg       in         cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// Each input byte yields ratio outputs, one per cycle while the output is not
// stalled (a single output in bypass); the output recurrence runs through the
// previous-output register. A new byte is taken when the filter stage is empty
// or emits its last output, and passes the filter stage, then the output register.
// Reset restores ratio 1, alpha 1.0 and a zero filter history.
// A stalled output holds its register and the item in the filter stage waits.
`default_nettype none

module u8_audio_upsample_lowpass_unit
  import u8up_pkg::*;
#(
  parameter int unsigned MaxRatio = MAX_RATIO_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Input samples.
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // [7:0] sample_byte
  input  wire logic                  s_axis_tuser,   // [0] new_sound
  // Output samples.
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [31:0]                m_axis_tdata,   // [15:0] left_sample, [31:16] right_sample
  output logic                       m_axis_tlast,
  // Configuration writes.
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire cfg_idx_e              cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned RatW = $clog2(MaxRatio + 1);
  localparam int unsigned CntW = $clog2(MaxRatio);

  // Configuration registers, stored already saturated.
  logic [RatW-1:0] ratio_q, ratio_d;
  logic [15:0]     alpha_q, alpha_d;
  logic [15:0]     beta_q;

  // Filter stage holding the item in progress.
  logic                       s1_valid_q;
  logic signed [T1_W-1:0]     t1_q;
  logic signed [SAMPLE_W-1:0] x_q;
  logic                       ns_q;
  logic [CntW-1:0]            cnt_q;
  logic signed [SAMPLE_W-1:0] prev_q;

  // Output register.
  logic                       m_valid_q;
  logic signed [SAMPLE_W-1:0] m_data_q;
  logic                       m_last_q;

  logic                       adv;
  logic                       emit;
  logic                       emit_last;
  logic [RatW-1:0]            cnt_ext;
  logic signed [SAMPLE_W-1:0] x_in;
  logic signed [32:0]         xa;
  logic signed [32:0]         xa_adj;
  logic signed [SAMPLE_W-1:0] y;
  lpf_ctrl_t                  ctrl;
  logic [RATIO_W-1:0]         ratio_wr;

  assign cfg_ready_o = 1'b1;

  // Saturate register writes: ratio into 1..MaxRatio, alpha to at most 1.0.
  always_comb begin
    ratio_wr = cfg_data_i[RATIO_W-1:0];
    if (ratio_wr == '0) begin
      ratio_d = RatW'(1);
    end else if (32'(ratio_wr) > MaxRatio) begin
      ratio_d = RatW'(MaxRatio);
    end else begin
      ratio_d = RatW'(ratio_wr);
    end
    alpha_d = (cfg_data_i > ALPHA_ONE) ? ALPHA_ONE : cfg_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= RatW'(1);
      alpha_q <= ALPHA_ONE;
      beta_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RATIO: ratio_q <= ratio_d;
        CFG_ALPHA: begin
          alpha_q <= alpha_d;
          beta_q  <= ALPHA_ONE - alpha_d;
        end
      endcase
    end
  end

  // Widen the byte and scale it by alpha on the way into the filter stage.
  assign x_in   = {~s_axis_tdata[7], s_axis_tdata[6:0], s_axis_tdata};
  assign xa     = x_in * $signed({1'b0, alpha_q});
  assign xa_adj = xa + (xa[32] ? 33'sd32767 : 33'sd0);

  // Output register advances when empty or when its result is taken.
  assign adv       = !m_valid_q || m_axis_tready;
  assign emit      = s1_valid_q && adv;
  assign cnt_ext   = RatW'(cnt_q);
  assign emit_last = (cnt_ext == ratio_q - RatW'(1));

  assign s_axis_tready = !s1_valid_q || (emit && emit_last);

  assign ctrl.bypass     = (ratio_q == RatW'(1));
  assign ctrl.clear_hist = ns_q && (cnt_q == '0);

  u8up_lpf u_lpf (
    .t1_i   (t1_q),
    .x_i    (x_q),
    .beta_i (beta_q),
    .prev_i (prev_q),
    .ctrl_i (ctrl),
    .y_o    (y)
  );

  // Filter stage control: load on transfer, free after the last output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      cnt_q      <= '0;
      prev_q     <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        s1_valid_q <= 1'b1;
      end else if (emit && emit_last) begin
        s1_valid_q <= 1'b0;
      end
      if (emit) begin
        prev_q <= y;
        cnt_q  <= emit_last ? '0 : cnt_q + CntW'(1);
      end
    end
  end

  // Filter stage payload.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      t1_q <= xa_adj[31:15];
      x_q  <= x_in;
      ns_q <= s_axis_tuser;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_data_q <= y;
      m_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_data_q, m_data_q};
  assign m_axis_tlast  = m_last_q;

  `include "u8_audio_upsample_lowpass_unit_macros.svh"

  `U8UP_ASSERT(a_cnt_in_range, s1_valid_q |-> (cnt_ext < ratio_q), "output count beyond ratio")
  `U8UP_ASSERT(a_bypass_single, (emit && ctrl.bypass) |-> emit_last, "bypass item not single")
  `U8UP_ASSERT(a_accept_fills, (s_axis_tvalid && s_axis_tready) |=> s1_valid_q, "accepted item lost")
  `U8UP_ASSERT(a_last_frees, (emit && emit_last && !s_axis_tvalid) |=> !s1_valid_q, "stage not freed")
  `U8UP_ASSERT_ALWAYS(a_ratio_nonzero, !rst_ni || (ratio_q != '0), "ratio register holds zero")

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 8-bit mono to 16-bit stereo upsampler with low-pass filter.
module testbench;
  import u8up_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 6;
  localparam int unsigned MaxReported   = 10;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned PhaseSamples  = 40;

  // Tracks filter state and settings, predicts output samples and compares them.
  class upsample_lowpass_scoreboard;
    typedef struct packed {
      logic [15:0] left;
      logic [15:0] right;
      logic        last_flag;
    } stereo_out_t;

    logic [RATIO_W-1:0]    ratio_reg;
    logic [CFG_DATA_W-1:0] alpha_reg;
    int                    history;
    stereo_out_t           expected_outputs[$];
    int                    failures;

    function new();
      ratio_reg = 1;
      alpha_reg = ALPHA_ONE;
      history   = 0;
      failures  = 0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_RATIO) begin
        ratio_reg = data[RATIO_W-1:0];
      end else begin
        alpha_reg = data;
      end
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction

    // Widen the byte, then either pass it through or run the held value through
    // the one-pole filter once per output.
    function void note_sample(logic [7:0] sample_byte, logic new_sound);
      logic [15:0] raw;
      int          widened;
      int          steps;
      longint      unity;
      longint      coef;
      longint      scaled;
      longint      acc;
      longint      filtered;
      stereo_out_t res;
      raw     = {sample_byte, sample_byte} ^ 16'h8000;
      widened = $signed(raw);
      unity   = longint'(ALPHA_ONE);
      if (new_sound) begin
        history = 0;
      end
      steps = (ratio_reg == 0) ? 1 : int'(ratio_reg);
      if (steps > int'(MAX_RATIO_DEF)) begin
        steps = MAX_RATIO_DEF;
      end
      coef = longint'(alpha_reg);
      if (coef > unity) begin
        coef = unity;
      end
      if (steps == 1) begin
        history       = widened;
        res.left      = raw;
        res.right     = raw;
        res.last_flag = 1'b1;
        expected_outputs.push_back(res);
        return;
      end
      for (int k = 0; k < steps; k++) begin
        // Division on longint truncates toward zero, as the filter requires.
        scaled   = (longint'(widened) * coef) / unity;
        acc      = scaled * unity + (unity - coef) * longint'(history);
        filtered = acc / unity;
        if (filtered > 32767) begin
          filtered = 32767;
        end
        if (filtered < -32768) begin
          filtered = -32768;
        end
        history       = int'(filtered);
        res.left      = filtered[15:0];
        res.right     = filtered[15:0];
        res.last_flag = (k == steps - 1);
        expected_outputs.push_back(res);
      end
    endfunction

    function void check_output(logic [31:0] tdata, logic tlast);
      stereo_out_t want;
      if (expected_outputs.size() == 0) begin
        failures++;
        if (failures <= MaxReported) begin
          $display("Unexpected output: left %0d right %0d last %0b",
                   $signed(tdata[15:0]), $signed(tdata[31:16]), tlast);
        end
        return;
      end
      want = expected_outputs.pop_front();
      if (tdata[15:0] !== want.left || tdata[31:16] !== want.right ||
          tlast !== want.last_flag) begin
        failures++;
        if (failures <= MaxReported) begin
          $display("Output mismatch: left exp %0d got %0d, right exp %0d got %0d, last exp %0b got %0b",
                   $signed(want.left), $signed(tdata[15:0]),
                   $signed(want.right), $signed(tdata[31:16]),
                   want.last_flag, tlast);
        end
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;   // [7:0] sample_byte
  logic                  s_axis_tuser;   // [0] new_sound
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;   // [15:0] left_sample, [31:16] right_sample
  logic                  m_axis_tlast;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  cfg_idx_e              cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  upsample_lowpass_scoreboard sb;
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;

  u8_audio_upsample_lowpass_unit #(
    .MaxRatio(MAX_RATIO_DEF)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Output backpressure in random bursts.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 16);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Every transfer is observed at the rising edge and fed to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        sb.set_register(cfg_index_i, cfg_data_i);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_sample(s_axis_tdata, s_axis_tuser);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_output(m_axis_tdata, m_axis_tlast);
      end
    end
  end

  // Watchdog: too many cycles without any transfer ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Register write; starts and ends on a falling edge.
  task automatic write_cfg_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one sample, with an optional idle burst first. Valid stays high
  // afterwards so back-to-back samples stream without a bubble.
  task automatic send_sample(logic [7:0] sample_byte, logic new_sound);
    int gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample_byte;
    s_axis_tuser  <= new_sound;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Stop offering samples and wait until every predicted output has arrived.
  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  initial begin
    int                    ratio_pick;
    int                    run_left;
    logic [CFG_DATA_W-1:0] cfg_word;
    logic [7:0]            byte_val;
    logic                  ns_val;

    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_RATIO;
    cfg_data_i    = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    rx_idle_en <= 1'b1;

    // Reset settings: bypass at unity gain, including a new sound.
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd128, 1'b1);
    send_sample(8'd127, 1'b0);
    drain_outputs();

    // Typical ratio with half-strength filter; new sound in mid history.
    write_cfg_reg(CFG_RATIO, 16'd4);
    write_cfg_reg(CFG_ALPHA, 16'd16384);
    send_sample(8'd255, 1'b0);
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b1);
    send_sample(8'd128, 1'b0);
    drain_outputs();

    // Ratio zero falls back to bypass; new sound in bypass.
    write_cfg_reg(CFG_RATIO, 16'd0);
    send_sample(8'd200, 1'b1);
    send_sample(8'd1, 1'b0);
    drain_outputs();

    // Ratio and alpha above their limits saturate.
    write_cfg_reg(CFG_RATIO, 16'hFFFF);
    write_cfg_reg(CFG_ALPHA, 16'hFFFF);
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b1);
    drain_outputs();

    // Zero alpha freezes the history; a new sound forces it to zero.
    write_cfg_reg(CFG_RATIO, 16'd2);
    write_cfg_reg(CFG_ALPHA, 16'd0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd0, 1'b1);
    send_sample(8'd77, 1'b0);
    drain_outputs();

    // Largest ratio with the weakest nonzero filter.
    write_cfg_reg(CFG_RATIO, 16'd8);
    write_cfg_reg(CFG_ALPHA, 16'd1);
    send_sample(8'd255, 1'b1);
    send_sample(8'd0, 1'b0);
    drain_outputs();

    write_cfg_reg(CFG_RATIO, 16'd9);
    write_cfg_reg(CFG_ALPHA, 16'd32768);
    send_sample(8'd100, 1'b0);
    drain_outputs();

    write_cfg_reg(CFG_RATIO, 16'd3);
    write_cfg_reg(CFG_ALPHA, 16'd32767);
    send_sample(8'd255, 1'b0);
    send_sample(8'd0, 1'b0);
    drain_outputs();

    // Random phases: each picks settings, then streams sounds of random content.
    run_left = 0;
    for (int phase = 0; phase < RandomPhases; phase++) begin
      if (phase == RandomPhases - 1) begin
        tx_idle_en = 1'b0;
        rx_idle_en <= 1'b0;
      end else begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en <= ($urandom_range(0, 3) != 0);
      end

      case ($urandom_range(0, 3))
        0: ratio_pick = 4;
        1: ratio_pick = 8;
        2: ratio_pick = $urandom_range(0, 15);
        default: ratio_pick = $urandom_range(1, 3);
      endcase
      // Upper data bits are ignored by the ratio register; randomize them anyway.
      cfg_word = 16'($urandom);
      cfg_word[RATIO_W-1:0] = ratio_pick[RATIO_W-1:0];
      write_cfg_reg(CFG_RATIO, cfg_word);

      case ($urandom_range(0, 4))
        0: cfg_word = 16'd0;
        1: cfg_word = ALPHA_ONE;
        2: cfg_word = 16'($urandom_range(32768, 65535));
        3: cfg_word = 16'($urandom_range(1, 32767));
        default: cfg_word = 16'($urandom_range(1, 2048));
      endcase
      write_cfg_reg(CFG_ALPHA, cfg_word);

      for (int i = 0; i < PhaseSamples; i++) begin
        // A sound starts with the new-sound flag; now and then the flag is
        // missing at a start or shows up inside a sound.
        if (run_left == 0) begin
          run_left = $urandom_range(1, 16);
          ns_val   = ($urandom_range(0, 7) != 0);
        end else begin
          ns_val = ($urandom_range(0, 15) == 0);
        end
        run_left--;
        case ($urandom_range(0, 7))
          0: byte_val = 8'd0;
          1: byte_val = 8'd255;
          2: byte_val = 8'd128;
          default: byte_val = 8'($urandom_range(0, 255));
        endcase
        send_sample(byte_val, ns_val);
      end
      drain_outputs();
    end

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/u8up_pkg.sv
sv/u8up_lpf.sv
sv/u8_audio_upsample_lowpass_unit.sv
test/testbench.sv
